@@ hw/rtl/drqs_pkg.sv @@
// ----------------------------------------------------------------------------
// drqs_pkg
// Shared types and constants of the deduplicating request queue scheduler.
// ----------------------------------------------------------------------------
package drqs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_BITS    = 24;
   localparam int HANDLE_BITS = 8;

   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_BITS  = KEY_BITS + HANDLE_BITS;
   localparam int PHASE_BITS  = 4;
   localparam int PERIOD_BITS = 4;
   localparam int ACTION_BITS = 3;

   localparam logic [LEVEL_BITS-1:0]  FULL_LEVEL   = LEVEL_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS:0]      DEPTH_WIDE   = (PTR_BITS + 1)'(QUEUE_DEPTH);
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(4);

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_QUEUED = 3'd0,
      ACT_DUP    = 3'd1,
      ACT_FULL   = 3'd2,
      ACT_VIEW   = 3'd3,
      ACT_FRAME  = 3'd4,
      ACT_IDLE   = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_MOD,
      ENG_POP,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      logic                   is_push;
      logic                   link_up;
      logic [KEY_BITS-1:0]    key;
      logic [HANDLE_BITS-1:0] handle;
   } item_type;

   typedef struct packed {
      action_type             action;
      logic [HANDLE_BITS-1:0] sent_handle;
      logic [KEY_BITS-1:0]    sent_key;
      logic [LEVEL_BITS-1:0]  queue_level;
   } result_type;

   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] base,
                                                   input logic [PTR_BITS-1:0] offs);
      logic [PTR_BITS:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_WIDE) begin
         sum = sum - DEPTH_WIDE;
      end
      return sum[PTR_BITS-1:0];
   endfunction

endpackage

@@ hw/rtl/drqs_ram.sv @@
// ----------------------------------------------------------------------------
// drqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/drqs_front.sv @@
// ----------------------------------------------------------------------------
// drqs_front
// Accepts request transactions, classifies them and holds them in a
// two-entry queue ahead of the engine.
// ----------------------------------------------------------------------------
module drqs_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic                            req_link_up,
   input  logic [drqs_pkg::KEY_BITS-1:0]   req_object_key,
   input  logic [drqs_pkg::HANDLE_BITS-1:0] req_frame_handle,
   output logic                            item_valid,
   input  logic                            item_ready,
   output drqs_pkg::item_type              item
);
   import drqs_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   new_item;

   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   assign push = req_valid && req_ready;
   assign pop  = item_valid && item_ready;

   always_comb begin
      new_item.is_push = (req_cmd == CMD_PUSH);
      new_item.link_up = req_link_up;
      new_item.key     = req_object_key;
      new_item.handle  = req_frame_handle;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ hw/rtl/drqs_engine.sv @@
// ----------------------------------------------------------------------------
// drqs_engine
// Carries out queued transactions: duplicate scan over the entry RAM,
// append, view/frame decision on ticks and the result register.
// ----------------------------------------------------------------------------
module drqs_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   output logic                             item_ready,
   input  drqs_pkg::item_type               item,
   input  logic                             csr_wr_en,
   input  logic [drqs_pkg::PERIOD_BITS-1:0] csr_wr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output drqs_pkg::result_type             rsp
);
   import drqs_pkg::*;

   eng_state_type          state_ff, state_in;
   item_type               item_ff, item_in;
   logic [LEVEL_BITS-1:0]  cnt_ff, cnt_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [PHASE_BITS-1:0]  rem_ff, rem_in;
   logic [PTR_BITS-1:0]    head_ff, head_in;
   logic [LEVEL_BITS-1:0]  fill_ff, fill_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   action_type             act_ff, act_in;
   logic [KEY_BITS-1:0]    skey_ff, skey_in;
   logic [HANDLE_BITS-1:0] shandle_ff, shandle_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   logic                   ram_wr_en, ram_rd_en;
   logic [PTR_BITS-1:0]    ram_wr_addr, ram_rd_addr;
   logic [ENTRY_BITS-1:0]  ram_rd_data;
   logic [KEY_BITS-1:0]    rd_key;
   logic [HANDLE_BITS-1:0] rd_handle;

   logic                   hit, issue, scan_end, out_free, rem_ge;
   logic [PERIOD_BITS-1:0] period_eff;

   drqs_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({item_ff.key, item_ff.handle}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_key     = ram_rd_data[ENTRY_BITS-1:HANDLE_BITS];
   assign rd_handle  = ram_rd_data[HANDLE_BITS-1:0];
   assign hit        = cmp_vld_ff && (rd_key == item_ff.key);
   assign issue      = !hit && (cnt_ff < fill_ff);
   assign scan_end   = !hit && !issue && !cmp_vld_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign period_eff = (period_ff == '0) ? PERIOD_BITS'(1) : period_ff;
   assign rem_ge     = (rem_ff >= period_eff);

   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;
   assign item_ready = (state_ff == ENG_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (item_valid) begin
               if (item.is_push) begin
                  state_in = ENG_SCAN;
               end else if (!item.link_up) begin
                  state_in = ENG_DONE;
               end else begin
                  state_in = ENG_MOD;
               end
            end
         end
         ENG_SCAN: begin
            if (hit || scan_end) begin
               state_in = ENG_DONE;
            end
         end
         ENG_MOD: begin
            if (!rem_ge) begin
               if (fill_ff == '0 || rem_ff == '0) begin
                  state_in = ENG_DONE;
               end else begin
                  state_in = ENG_POP;
               end
            end
         end
         ENG_POP: begin
            state_in = ENG_DONE;
         end
         ENG_DONE: begin
            if (out_free) begin
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      cmp_vld_in   = 1'b0;
      rem_in       = rem_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      phase_in     = phase_ff;
      period_in    = csr_wr_en ? csr_wr_data : period_ff;
      act_in       = act_ff;
      skey_in      = skey_ff;
      shandle_in   = shandle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ptr_add(head_ff, fill_ff[PTR_BITS-1:0]);
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ptr_add(head_ff, cnt_ff[PTR_BITS-1:0]);
      case (state_ff)
         ENG_IDLE: begin
            item_in    = item;
            cnt_in     = '0;
            rem_in     = phase_ff;
            skey_in    = '0;
            shandle_in = '0;
            act_in     = ACT_IDLE;
            if (item_valid && !item.is_push && !item.link_up) begin
               phase_in = phase_ff + PHASE_BITS'(1);
            end
         end
         ENG_SCAN: begin
            ram_rd_en  = issue;
            cnt_in     = cnt_ff + LEVEL_BITS'(issue);
            cmp_vld_in = issue;
            if (hit) begin
               act_in = ACT_DUP;
            end else if (scan_end) begin
               if (fill_ff == FULL_LEVEL) begin
                  act_in = ACT_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  fill_in   = fill_ff + LEVEL_BITS'(1);
                  act_in    = ACT_QUEUED;
               end
            end
         end
         ENG_MOD: begin
            if (rem_ge) begin
               rem_in = rem_ff - PHASE_BITS'(period_eff);
            end else begin
               phase_in = phase_ff + PHASE_BITS'(1);
               act_in   = ACT_VIEW;
               if (fill_ff != '0 && rem_ff != '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = head_ff;
               end
            end
         end
         ENG_POP: begin
            act_in     = ACT_FRAME;
            skey_in    = rd_key;
            shandle_in = rd_handle;
            head_in    = ptr_add(head_ff, PTR_BITS'(1));
            fill_in    = fill_ff - LEVEL_BITS'(1);
         end
         ENG_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.action      = act_ff;
               rsp_in.sent_handle = shandle_ff;
               rsp_in.sent_key    = skey_ff;
               rsp_in.queue_level = fill_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         cmp_vld_ff   <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         phase_ff     <= '0;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      act_ff     <= act_in;
      skey_ff    <= skey_in;
      shandle_ff <= shandle_in;
      rsp_ff     <= rsp_in;
   end

endmodule

@@ hw/rtl/dedup_request_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// dedup_request_queue_scheduler
// Request FIFO with duplicate-key rejection and periodic view requests.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+--------------
//   request  | req_cmd, req_link_up, req_object_key, ...    | req_valid/ready
//   response | rsp_action, rsp_sent_handle/key, queue_level | rsp_valid/ready
//   csr      | csr_wr_data (view period)                    | csr_wr_en
//
// For a push, the key scan reads one queued entry per cycle from the entry
// RAM. For a tick with the link up, the phase-modulo loop subtracts the
// period once per cycle. A two-entry input queue takes transactions while
// the engine works and a result register holds the answer until taken.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dedup_request_queue_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic                              req_link_up,
   input  logic [drqs_pkg::KEY_BITS-1:0]     req_object_key,
   input  logic [drqs_pkg::HANDLE_BITS-1:0]  req_frame_handle,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [drqs_pkg::ACTION_BITS-1:0]  rsp_action,
   output logic [drqs_pkg::HANDLE_BITS-1:0]  rsp_sent_handle,
   output logic [drqs_pkg::KEY_BITS-1:0]     rsp_sent_key,
   output logic [drqs_pkg::LEVEL_BITS-1:0]   rsp_queue_level,
   input  logic                              csr_wr_en,
   input  logic [drqs_pkg::PERIOD_BITS-1:0]  csr_wr_data
);
   import drqs_pkg::*;

   logic       item_valid, item_ready;
   item_type   item;
   result_type rsp;

   drqs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_link_up      (req_link_up),
      .req_object_key   (req_object_key),
      .req_frame_handle (req_frame_handle),
      .item_valid       (item_valid),
      .item_ready       (item_ready),
      .item             (item)
   );

   drqs_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   assign rsp_action      = rsp.action;
   assign rsp_sent_handle = rsp.sent_handle;
   assign rsp_sent_key    = rsp.sent_key;
   assign rsp_queue_level = rsp.queue_level;

endmodule

@@ dv/dedup_request_queue_scheduler_checker.sv @@
// ----------------------------------------------------------------------------
// dedup_request_queue_scheduler_checker
// Passive scoreboard for the request queue scheduler. It mirrors the queue,
// the tick phase and the view period from the observed request and CSR
// transactions, and compares each response transaction, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dedup_request_queue_scheduler_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_cmd,
   input  logic                             req_link_up,
   input  logic [drqs_pkg::KEY_BITS-1:0]    req_object_key,
   input  logic [drqs_pkg::HANDLE_BITS-1:0] req_frame_handle,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [drqs_pkg::ACTION_BITS-1:0] rsp_action,
   input  logic [drqs_pkg::HANDLE_BITS-1:0] rsp_sent_handle,
   input  logic [drqs_pkg::KEY_BITS-1:0]    rsp_sent_key,
   input  logic [drqs_pkg::LEVEL_BITS-1:0]  rsp_queue_level,
   input  logic                             csr_wr_en,
   input  logic [drqs_pkg::PERIOD_BITS-1:0] csr_wr_data,
   output int                               mismatches,
   output int                               outstanding
);
   import drqs_pkg::*;

   logic [KEY_BITS-1:0]    slot_keys    [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0] slot_handles [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    head;
   logic [LEVEL_BITS-1:0]  level;
   logic [PHASE_BITS-1:0]  phase;
   logic [PERIOD_BITS-1:0] period;
   result_type             awaited_responses [$];
   result_type             want;
   int                     rsp_count;

   function automatic result_type schedule_response(input logic                   cmd,
                                                    input logic                   link,
                                                    input logic [KEY_BITS-1:0]    key,
                                                    input logic [HANDLE_BITS-1:0] handle);
      result_type          r;
      logic                hit;
      logic [PTR_BITS-1:0] slot;
      int                  divisor;
      r             = '0;
      r.sent_handle = '0;
      r.sent_key    = '0;
      if (cmd == CMD_PUSH) begin
         hit = 1'b0;
         for (int n = 0; n < int'(level); n++) begin
            slot = PTR_BITS'((int'(head) + n) % QUEUE_DEPTH);
            if (slot_keys[slot] == key) begin
               hit = 1'b1;
            end
         end
         // duplicate wins over full
         if (hit) begin
            r.action = ACT_DUP;
         end else if (int'(level) >= QUEUE_DEPTH) begin
            r.action = ACT_FULL;
         end else begin
            slot               = PTR_BITS'((int'(head) + int'(level)) % QUEUE_DEPTH);
            slot_keys[slot]    = key;
            slot_handles[slot] = handle;
            level              = level + 1'b1;
            r.action           = ACT_QUEUED;
         end
      end else begin
         if (!link) begin
            r.action = ACT_IDLE;
         end else begin
            divisor = (period == '0) ? 1 : int'(period);
            if (level == '0 || (int'(phase) % divisor) == 0) begin
               r.action = ACT_VIEW;
            end else begin
               r.sent_key    = slot_keys[head];
               r.sent_handle = slot_handles[head];
               head          = PTR_BITS'((int'(head) + 1) % QUEUE_DEPTH);
               level         = level - 1'b1;
               r.action      = ACT_FRAME;
            end
         end
         phase = phase + 1'b1;
      end
      r.queue_level = level;
      return r;
   endfunction

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp);
      $display("response %0d: %s = 0x%0h, expected 0x%0h", rsp_count, field, got, exp);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head      = '0;
         level     = '0;
         phase     = '0;
         period    = PERIOD_RESET;
         rsp_count = 0;
         awaited_responses.delete();
         outstanding <= 0;
      end else begin
         if (csr_wr_en) begin
            period = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            awaited_responses.push_back(schedule_response(req_cmd, req_link_up,
                                                          req_object_key, req_frame_handle));
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               report("unrequested transaction, action", 32'(rsp_action), 32'(0));
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_action !== want.action) begin
                  report("action", 32'(rsp_action), 32'(want.action));
               end
               if (rsp_sent_handle !== want.sent_handle) begin
                  report("sent_handle", 32'(rsp_sent_handle), 32'(want.sent_handle));
               end
               if (rsp_sent_key !== want.sent_key) begin
                  report("sent_key", 32'(rsp_sent_key), 32'(want.sent_key));
               end
               if (rsp_queue_level !== want.queue_level) begin
                  report("queue_level", 32'(rsp_queue_level), 32'(want.queue_level));
               end
            end
            rsp_count++;
         end
         outstanding <= awaited_responses.size();
      end
   end

endmodule

@@ dv/tb_dedup_request_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_dedup_request_queue_scheduler
// Stimulus and verdict for the deduplicating request queue scheduler. A
// directed opening covers duplicate and full drops, disconnected ticks and
// view slots; random phases then run under several view periods, each
// written while the block is drained, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_dedup_request_queue_scheduler;
   import drqs_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASE_ITEMS  = 240;
   localparam int POOL_SIZE    = 24;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_cmd;
   logic                   req_link_up;
   logic [KEY_BITS-1:0]    req_object_key;
   logic [HANDLE_BITS-1:0] req_frame_handle;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [ACTION_BITS-1:0] rsp_action;
   logic [HANDLE_BITS-1:0] rsp_sent_handle;
   logic [KEY_BITS-1:0]    rsp_sent_key;
   logic [LEVEL_BITS-1:0]  rsp_queue_level;
   logic                   csr_wr_en;
   logic [PERIOD_BITS-1:0] csr_wr_data;

   int                     mismatches;
   int                     outstanding;
   int                     quiet_cycles;
   int                     push_pct;
   logic                   no_gaps;
   logic [KEY_BITS-1:0]    key_pool [POOL_SIZE];
   logic [PERIOD_BITS-1:0] period_plan [6];

   dedup_request_queue_scheduler dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_link_up      (req_link_up),
      .req_object_key   (req_object_key),
      .req_frame_handle (req_frame_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_sent_handle  (rsp_sent_handle),
      .rsp_sent_key     (rsp_sent_key),
      .rsp_queue_level  (rsp_queue_level),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   dedup_request_queue_scheduler_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_link_up      (req_link_up),
      .req_object_key   (req_object_key),
      .req_frame_handle (req_frame_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_sent_handle  (rsp_sent_handle),
      .rsp_sent_key     (rsp_sent_key),
      .rsp_queue_level  (rsp_queue_level),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   task automatic offer(input logic                   cmd,
                        input logic                   link,
                        input logic [KEY_BITS-1:0]    key,
                        input logic [HANDLE_BITS-1:0] handle,
                        input int                     gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_link_up      <= link;
      req_object_key   <= key;
      req_frame_handle <= handle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic random_run(input int count);
      int                  seg_left;
      int                  pick;
      logic                cmd;
      logic                link;
      logic [KEY_BITS-1:0] key;
      seg_left = 0;
      for (int i = 0; i < count; i++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(15, 60);
            pick     = $urandom_range(0, 2);
            push_pct = (pick == 0) ? 80 : (pick == 1) ? 35 : 55;
            no_gaps  = ($urandom_range(0, 3) == 0);
         end
         seg_left--;
         cmd  = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_TICK;
         link = (cmd == CMD_TICK) ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
         key  = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : KEY_BITS'($urandom);
         offer(cmd, link, key, HANDLE_BITS'($urandom), no_gaps ? 0 : idle_gap());
      end
   endtask

   // lower valid, then hold off until every response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_view_period(input logic [PERIOD_BITS-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(50, 200)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_dedup_request_queue_scheduler: FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_PUSH;
      req_link_up      = 1'b0;
      req_object_key   = '0;
      req_frame_handle = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      push_pct         = 55;
      no_gaps          = 1'b0;
      key_pool[0]      = '0;
      key_pool[1]      = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         key_pool[i] = KEY_BITS'($urandom);
      end
      period_plan = '{4'd1, 4'd15, 4'd0, 4'd7, 4'd2, PERIOD_BITS'($urandom_range(0, 15))};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty queue view, disconnected tick, link ignored on push, duplicates
      offer(CMD_TICK, 1'b1, '0, '0, 0);
      offer(CMD_TICK, 1'b0, '1, '1, idle_gap());
      offer(CMD_PUSH, 1'b1, '0, '0, idle_gap());
      offer(CMD_PUSH, 1'b0, '0, '1, idle_gap());
      offer(CMD_PUSH, 1'b0, '1, '1, idle_gap());
      for (int k = 1; k <= QUEUE_DEPTH - 2; k++) begin
         offer(CMD_PUSH, 1'(k), KEY_BITS'(k), HANDLE_BITS'(k * 17), idle_gap());
      end
      // full queue: new key dropped as full, queued key still reported duplicate
      offer(CMD_PUSH, 1'b0, KEY_BITS'(24'h800000), HANDLE_BITS'(8'h5a), idle_gap());
      offer(CMD_PUSH, 1'b1, '1, '0, idle_gap());
      offer(CMD_TICK, 1'b1, '0, '0, idle_gap());
      offer(CMD_TICK, 1'b1, '0, '0, 0);
      offer(CMD_TICK, 1'b1, '0, '0, 0);

      random_run(200);
      foreach (period_plan[p]) begin
         set_view_period(period_plan[p]);
         random_run(PHASE_ITEMS);
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_dedup_request_queue_scheduler: PASS");
      end else begin
         $display("tb_dedup_request_queue_scheduler: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/drqs_pkg.sv
hw/rtl/drqs_ram.sv
hw/rtl/drqs_front.sv
hw/rtl/drqs_engine.sv
hw/rtl/dedup_request_queue_scheduler.sv
dv/dedup_request_queue_scheduler_checker.sv
dv/tb_dedup_request_queue_scheduler.sv
